### rtl/tlta_pkg.sv
// Shared widths, constants, FSM state and control types for the trigger
// live-time accumulator. No dependencies; used by every rtl/tlta_* file.
`default_nettype none

package tlta_pkg;

    // Field widths
    localparam int TIME_W = 42;
    localparam int CNT_W  = 16;
    localparam int ACC_W  = 48;

    // Digit-serial compare/subtract lanes
    localparam int DIGIT_W    = 6;
    localparam int NUM_DIGITS = TIME_W / DIGIT_W;
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

    // Narrow datapath: gaps of interest stay below 2^13 ms
    localparam int GAP_W  = 13;
    localparam int DEAD_W = 29;                 // 6145 * (2^16-1) < 2^29
    localparam int TERM_W = DEAD_W + 1;         // signed term
    localparam int PROD_W = 43;                 // |term * num| < 2^41
    localparam int QUOT_W = PROD_W - 1;
    localparam int QCNT_W = $clog2(QUOT_W);

    localparam logic [GAP_W-1:0] GAP_MIN        = 13'd1000;
    localparam logic [GAP_W-1:0] GAP_MAX        = 13'd5000;
    localparam logic [GAP_W-1:0] TAIL_GAP_LIMIT = 13'd4500;
    localparam logic [GAP_W-1:0] DEAD_HALF_MS   = 13'd6145;  // 3072.5 ms

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SERIAL,
        ST_TERM,
        ST_PROD,
        ST_DIVGO,
        ST_DIV,
        ST_FIX,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } ser_ctl_t;

endpackage

`default_nettype wire

### rtl/tlta_serial_sub.sv
// Digit-serial subtractor lane: a - b, one digit per step, LSB first.
// Depends on tlta_pkg (widths, ser_ctl_t).
`default_nettype none

module tlta_serial_sub (
    input  wire logic                        aclk,
    input  wire tlta_pkg::ser_ctl_t          ctl_i,
    input  wire logic [tlta_pkg::TIME_W-1:0] a_i,
    input  wire logic [tlta_pkg::TIME_W-1:0] b_i,
    output logic      [tlta_pkg::TIME_W-1:0] diff_o,
    output logic                             borrow_o
);

    localparam int DSUM_W = tlta_pkg::DIGIT_W + 1;

    logic [tlta_pkg::TIME_W-1:0] a_sr_reg;
    logic [tlta_pkg::TIME_W-1:0] b_sr_reg;
    logic [tlta_pkg::TIME_W-1:0] d_sr_reg;
    logic                        borrow_reg;
    logic [DSUM_W-1:0]           dsum;

    assign dsum = {1'b0, a_sr_reg[tlta_pkg::DIGIT_W-1:0]}
                - {1'b0, b_sr_reg[tlta_pkg::DIGIT_W-1:0]}
                - DSUM_W'(borrow_reg);

    always_ff @(posedge aclk) begin
        if (ctl_i.load) begin
            a_sr_reg   <= a_i;
            b_sr_reg   <= b_i;
            borrow_reg <= 1'b0;
        end else if (ctl_i.step) begin
            a_sr_reg   <= a_sr_reg >> tlta_pkg::DIGIT_W;
            b_sr_reg   <= b_sr_reg >> tlta_pkg::DIGIT_W;
            d_sr_reg   <= {dsum[tlta_pkg::DIGIT_W-1:0],
                           d_sr_reg[tlta_pkg::TIME_W-1:tlta_pkg::DIGIT_W]};
            borrow_reg <= dsum[tlta_pkg::DIGIT_W];
        end
    end

    assign diff_o   = d_sr_reg;
    assign borrow_o = borrow_reg;

endmodule

`default_nettype wire

### rtl/tlta_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned.
// Depends on tlta_pkg (QUOT_W, QCNT_W, GAP_W).
`default_nettype none

module tlta_divider (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start_i,
    input  wire logic [tlta_pkg::QUOT_W-1:0] dividend_i,
    input  wire logic [tlta_pkg::GAP_W-1:0]  divisor_i,
    output logic                             done_o,
    output logic      [tlta_pkg::QUOT_W-1:0] quot_o
);

    localparam int QW = tlta_pkg::QUOT_W;
    localparam int GW = tlta_pkg::GAP_W;

    logic                        busy_reg;
    logic [tlta_pkg::QCNT_W-1:0] cnt_reg;
    logic [GW-1:0]               rem_reg;
    logic [QW-1:0]               q_reg;
    logic [GW:0]                 shifted;
    logic [GW:0]                 trial;
    logic                        fits;

    assign shifted = {rem_reg, q_reg[QW-1]};
    assign trial   = shifted - {1'b0, divisor_i};
    assign fits    = shifted >= {1'b0, divisor_i};
    assign done_o  = busy_reg && (cnt_reg == tlta_pkg::QCNT_W'(QW - 1));
    assign quot_o  = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start_i) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= dividend_i;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial[GW-1:0] : shifted[GW-1:0];
            q_reg   <= {q_reg[QW-2:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
            if (done_o) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // A new division never starts on top of a running one
    assert property (@(posedge aclk) disable iff (!aresetn) start_i |-> !busy_reg)
        else $error("divider restarted while busy");

    // Once busy, the count moves on every cycle until the last bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !done_o) |=> (busy_reg && cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("divider stalled mid-run");

    // Busy only ever rises after a start
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(busy_reg) |-> $past(start_i))
        else $error("divider busy without start");

endmodule

`default_nettype wire

### rtl/trigger_live_time_accumulator_top.sv
// One record is in flight at a time: s_ready is high only in idle, and the steps
// are accept, seven 6-bit serial digits, term, accumulate and output. The record
// that closes the window with a prorated tail also takes product, start, the 42
// quotient bits of the divider and a sign fix, so its result comes later.
// A stalled result holds the next one.
// Reset (aresetn low, synchronous): total, previous record, closed flag cleared.
`default_nettype none

// Top level of the trigger live-time accumulator.
// Depends on tlta_pkg, tlta_serial_sub and tlta_divider.
// Reset also sets window start 0, window end all ones and empties the output.
module trigger_live_time_accumulator_top (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // configuration write port
    input  wire logic                                   cfg_we,
    input  wire logic [tlta_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [tlta_pkg::TIME_W-1:0]            cfg_wdata,
    // record input channel
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [tlta_pkg::TIME_W-1:0]            s_time_ms,
    input  wire logic [tlta_pkg::CNT_W-1:0]             s_eff_trig_count,
    input  wire logic [tlta_pkg::CNT_W-1:0]             s_coin_trig_count,
    // result channel
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [tlta_pkg::ACC_W-1:0]           m_live_time_half_ms,
    output logic                                        m_record_counted,
    output logic                                        m_window_done
);

    localparam int TW = tlta_pkg::TIME_W;
    localparam int CW = tlta_pkg::CNT_W;
    localparam int AW = tlta_pkg::ACC_W;
    localparam int GW = tlta_pkg::GAP_W;
    localparam int MW = tlta_pkg::TERM_W;
    localparam int PW = tlta_pkg::PROD_W;
    localparam int QW = tlta_pkg::QUOT_W;

    tlta_pkg::state_t state_reg, state_next;

    // Configuration and persistent record state
    logic [TW-1:0] window_start_reg;
    logic [TW-1:0] window_end_reg;
    logic [TW-1:0] prev_time_reg;
    logic [CW-1:0] prev_eff_reg;
    logic [CW-1:0] prev_coin_reg;
    logic [AW-1:0] acc_reg;
    logic          closed_reg;

    // Per-transaction working registers
    logic [CW-1:0]                  d_eff_reg;
    logic [CW-1:0]                  d_coin_reg;
    logic [tlta_pkg::DIG_CNT_W-1:0] dig_cnt_reg;
    logic [GW-1:0]                  gap13_reg;
    logic [GW-1:0]                  num_reg;
    logic signed [MW-1:0]           term_reg;
    logic [PW-1:0]                  prod_reg;
    logic                           add_en_reg;
    logic                           close_pend_reg;

    // Output register
    logic          m_valid_reg;
    logic [AW-1:0] m_live_reg;
    logic          m_counted_reg;
    logic          m_done_reg;

    // Control
    tlta_pkg::ser_ctl_t ser_ctl;
    logic               div_start;
    logic               div_done;
    logic [QW-1:0]      div_quot;
    logic               add_decide;
    logic               close_decide;

    // Serial lane results
    logic [TW-1:0] gap_diff;
    logic          gap_borrow;     // time went backwards
    logic          past_borrow;    // record lies past the window end
    logic          start_borrow;   // record lies before the window start
    logic [TW-1:0] num_diff;
    logic          num_borrow;     // window end before previous record

    // ------------------------------------------------------------------
    // Four digit-serial lanes, all loaded at accept and stepped together.
    //   gap  = time - prev_time
    //   past : end - time borrows  <=> time > end
    //   start: time - start borrows <=> time < start
    //   num  = end - prev_time (tail numerator before clamping)
    // ------------------------------------------------------------------
    tlta_serial_sub u_gap_lane (
        .aclk     (aclk),
        .ctl_i    (ser_ctl),
        .a_i      (s_time_ms),
        .b_i      (prev_time_reg),
        .diff_o   (gap_diff),
        .borrow_o (gap_borrow)
    );

    tlta_serial_sub u_end_lane (
        .aclk     (aclk),
        .ctl_i    (ser_ctl),
        .a_i      (window_end_reg),
        .b_i      (s_time_ms),
        .diff_o   (),
        .borrow_o (past_borrow)
    );

    tlta_serial_sub u_start_lane (
        .aclk     (aclk),
        .ctl_i    (ser_ctl),
        .a_i      (s_time_ms),
        .b_i      (window_start_reg),
        .diff_o   (),
        .borrow_o (start_borrow)
    );

    tlta_serial_sub u_num_lane (
        .aclk     (aclk),
        .ctl_i    (ser_ctl),
        .a_i      (window_end_reg),
        .b_i      (prev_time_reg),
        .diff_o   (num_diff),
        .borrow_o (num_borrow)
    );

    // ------------------------------------------------------------------
    // Term evaluation (narrow once the gap is known to fit 13 bits)
    // ------------------------------------------------------------------
    logic [GW-1:0]                 gap_lo;
    logic                          gap_small;
    logic                          in_range;
    logic                          tail_ok;
    logic [CW-1:0]                 d_eff_m;
    logic [CW-1:0]                 d_coin_m;
    logic [tlta_pkg::DEAD_W-1:0]   dead_prod;
    logic [MW-1:0]                 term_calc;
    logic [GW-1:0]                 num_lo;
    logic                          num_big;
    logic [GW-1:0]                 num_clamped;

    assign gap_lo    = gap_diff[GW-1:0];
    assign gap_small = !gap_borrow && !(|gap_diff[TW-1:GW]);
    assign in_range  = gap_small && (gap_lo >= tlta_pkg::GAP_MIN)
                                 && (gap_lo <= tlta_pkg::GAP_MAX);
    assign tail_ok   = gap_small && (gap_lo != '0)
                                 && (gap_lo < tlta_pkg::TAIL_GAP_LIMIT);

    // out-of-range gaps zero both deltas
    assign d_eff_m  = in_range ? d_eff_reg  : '0;
    assign d_coin_m = in_range ? d_coin_reg : '0;

    assign dead_prod = tlta_pkg::DEAD_W'(tlta_pkg::DEAD_HALF_MS)
                     * tlta_pkg::DEAD_W'(d_eff_m);
    assign term_calc = MW'({gap_lo, 1'b0}) - MW'(dead_prod);

    // numerator clamped to [0, gap]
    assign num_lo      = num_diff[GW-1:0];
    assign num_big     = (|num_diff[TW-1:GW]) || (num_lo > gap_lo);
    assign num_clamped = num_borrow ? '0 : (num_big ? gap_lo : num_lo);

    // ------------------------------------------------------------------
    // Tail: term * num, then |product| / gap, sign restored afterwards
    // ------------------------------------------------------------------
    logic signed [GW:0]   num_s;
    logic signed [PW-1:0] prod_calc;
    logic [PW-1:0]        prod_mag;
    logic [MW-1:0]        quot_lo;
    logic [MW-1:0]        tail_term;

    assign num_s     = {1'b0, num_reg};
    assign prod_calc = term_reg * num_s;
    assign prod_mag  = prod_reg[PW-1] ? -prod_reg : prod_reg;
    assign quot_lo   = div_quot[MW-1:0];
    assign tail_term = prod_reg[PW-1] ? -quot_lo : quot_lo;

    tlta_divider u_divider (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (div_start),
        .dividend_i (prod_mag[QW-1:0]),
        .divisor_i  (gap13_reg),
        .done_o     (div_done),
        .quot_o     (div_quot)
    );

    // ------------------------------------------------------------------
    // Saturating accumulate
    // ------------------------------------------------------------------
    logic [AW:0]   acc_sum;
    logic [AW-1:0] acc_sat;

    assign acc_sum = {acc_reg[AW-1], acc_reg}
                   + {{(AW + 1 - MW){term_reg[MW-1]}}, term_reg};
    assign acc_sat = (acc_sum[AW] != acc_sum[AW-1])
                   ? (acc_sum[AW] ? tlta_pkg::ACC_MIN : tlta_pkg::ACC_MAX)
                   : acc_sum[AW-1:0];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlta_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        ser_ctl      = '0;
        div_start    = 1'b0;
        s_ready      = 1'b0;
        add_decide   = 1'b0;
        close_decide = 1'b0;
        case (state_reg)
            tlta_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ser_ctl.load = 1'b1;
                    state_next   = tlta_pkg::ST_SERIAL;
                end
            end
            tlta_pkg::ST_SERIAL: begin
                ser_ctl.step = 1'b1;
                if (dig_cnt_reg == tlta_pkg::DIG_CNT_W'(tlta_pkg::NUM_DIGITS - 1)) begin
                    state_next = tlta_pkg::ST_TERM;
                end
            end
            tlta_pkg::ST_TERM: begin
                state_next = tlta_pkg::ST_ACC;
                if (!closed_reg && past_borrow) begin
                    // first record past the end closes the window
                    close_decide = 1'b1;
                    if (tail_ok) begin
                        add_decide = 1'b1;
                        state_next = tlta_pkg::ST_PROD;
                    end
                end else if (!closed_reg && !start_borrow) begin
                    add_decide = (d_eff_m != '0) && (d_coin_m != '0);
                end
            end
            tlta_pkg::ST_PROD: begin
                state_next = tlta_pkg::ST_DIVGO;
            end
            tlta_pkg::ST_DIVGO: begin
                div_start  = 1'b1;
                state_next = tlta_pkg::ST_DIV;
            end
            tlta_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = tlta_pkg::ST_FIX;
                end
            end
            tlta_pkg::ST_FIX: begin
                state_next = tlta_pkg::ST_ACC;
            end
            tlta_pkg::ST_ACC: begin
                state_next = tlta_pkg::ST_OUT;
            end
            tlta_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = tlta_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tlta_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_start_reg <= '0;
            window_end_reg   <= '1;
            prev_time_reg    <= '0;
            prev_eff_reg     <= '0;
            prev_coin_reg    <= '0;
            acc_reg          <= '0;
            closed_reg       <= 1'b0;
            dig_cnt_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    tlta_pkg::CFG_WINDOW_START: window_start_reg <= cfg_wdata;
                    tlta_pkg::CFG_WINDOW_END:   window_end_reg   <= cfg_wdata;
                    default: ;
                endcase
            end

            // output register loads when free or draining, else drains
            if (state_reg == tlta_pkg::ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg   <= 1'b1;
                m_live_reg    <= acc_reg;
                m_counted_reg <= add_en_reg;
                m_done_reg    <= closed_reg;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                tlta_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        // lanes have sampled prev_time already
                        prev_time_reg <= s_time_ms;
                        prev_eff_reg  <= s_eff_trig_count;
                        prev_coin_reg <= s_coin_trig_count;
                        d_eff_reg     <= s_eff_trig_count - prev_eff_reg;
                        d_coin_reg    <= s_coin_trig_count - prev_coin_reg;
                        dig_cnt_reg   <= '0;
                    end
                end
                tlta_pkg::ST_SERIAL: begin
                    dig_cnt_reg <= dig_cnt_reg + 1'b1;
                end
                tlta_pkg::ST_TERM: begin
                    term_reg       <= $signed(term_calc);
                    gap13_reg      <= gap_lo;
                    num_reg        <= num_clamped;
                    add_en_reg     <= add_decide;
                    close_pend_reg <= close_decide;
                end
                tlta_pkg::ST_PROD: begin
                    prod_reg <= prod_calc;
                end
                tlta_pkg::ST_FIX: begin
                    term_reg <= $signed(tail_term);
                end
                tlta_pkg::ST_ACC: begin
                    if (add_en_reg) begin
                        acc_reg <= acc_sat;
                    end
                    closed_reg <= closed_reg | close_pend_reg;
                end
                default: ;
            endcase
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_live_time_half_ms = $signed(m_live_reg);
    assign m_record_counted    = m_counted_reg;
    assign m_window_done       = m_done_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A closed window stays closed until reset
    assert property (@(posedge aclk) disable iff (!aresetn) closed_reg |=> closed_reg)
        else $error("window reopened");

    // Nothing is added once the window has closed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tlta_pkg::ST_ACC && add_en_reg) |-> !closed_reg)
        else $error("term added after window closed");

    // The divider only sees a tail gap in (0, 4500)
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (gap13_reg != '0 && gap13_reg < tlta_pkg::TAIL_GAP_LIMIT))
        else $error("divider started with bad gap");

    // One record in flight: an accepted transaction drops ready next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction taken while busy");

endmodule

`default_nettype wire
